[src/cnlcd_pkg.sv]
// Package for the character LCD nibble write sequencer.
// Types, command bytes and register defaults shared by all modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cnlcd_pkg;

	// request modes
	typedef enum logic [2:0] {
		MODE_INIT    = 3'd0,
		MODE_CHAR    = 3'd1,
		MODE_COMMAND = 3'd2,
		MODE_CLEAR   = 3'd3,
		MODE_SHIFT   = 3'd4,
		MODE_GOTO    = 3'd5,
		MODE_NUMBER  = 3'd6
	} mode_t;

	// spare mode code: taken and dropped without a beat
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_ENABLE_PULSE   = 2'd0;
	localparam logic [1:0] CFG_COMMAND_SETTLE = 2'd1;
	localparam logic [1:0] CFG_CLEAR_SETTLE   = 2'd2;
	localparam logic [1:0] CFG_POWERUP_WAIT   = 2'd3;

	localparam int unsigned CFG_W = 16;

	localparam logic [CFG_W-1:0] RST_COMMAND_SETTLE = 16'd45;
	localparam logic [CFG_W-1:0] RST_CLEAR_SETTLE   = 16'd2000;
	localparam logic [CFG_W-1:0] RST_POWERUP_WAIT   = 16'd35000;

	// controller command bytes
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0F;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_SHIFT_LEFT   = 8'h18;
	localparam logic [7:0] CMD_SHIFT_RIGHT  = 8'h1C;
	localparam logic [7:0] LINE0_BASE       = 8'h80;
	localparam logic [7:0] LINE1_BASE       = 8'hC0;

	localparam logic [3:0] NIB_WAKE  = 4'h2;  // lone 4-bit mode nibble
	localparam logic [3:0] ASCII_DIG = 4'h3;  // high nibble of '0'..'9'

	localparam logic [3:0] INIT_LAST_IDX = 4'd9;

	// decimal conversion
	localparam int unsigned NUM_W    = 32;
	localparam int unsigned NDIG     = 10;
	localparam int unsigned BCD_W    = 4 * NDIG;
	localparam int unsigned STEP_W   = $clog2(NUM_W + 1);
	localparam logic [3:0]  NDIG_MAX = 4'(NDIG);

	typedef struct packed {
		logic        start;
		logic        shift;   // drop the top digit
	} dgt_ctrl_t;

	typedef struct packed {
		logic        busy;
		logic [3:0]  top;     // most significant remaining digit
	} dgt_stat_t;

	// init command list, in send order
	function automatic logic [7:0] init_cmd(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = CMD_FUNCTION_SET;
			2'd1:    b = CMD_DISPLAY_ON;
			2'd2:    b = CMD_CLEAR;
			default: b = CMD_ENTRY_MODE;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[src/char_lcd_nibble_write_sequencer.sv]
// Top level of the character LCD nibble write sequencer: request decode,
// beat sequencer, settle registers and output register. Depends on cnlcd_pkg, cnlcd_digit_unit.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  Input channel (in_valid/in_stall): one request beat per LCD operation.
//  in_stall is high from the accepting edge until the last result beat has
//  been handed to the output register; one request is in flight at a time.
//  Output channel (out_valid/out_stall): one beat per bus action, either a
//  nibble write (kind 0) or a pure wait (kind 1); last marks the final beat.
//  Non-number modes give 2 beats (10 for init), one beat per cycle while the
//  output does not stall. Number mode first runs the shift/add-3 unit, then
//  strips leading zeros at one digit per cycle (up to 9), then emits two beats
//  per digit, one per cycle while the output does not stall.
//  A request in mode 7 is taken and produces nothing.
//  A stall on the output freezes the sequencer with the beat held in the
//  output register; nothing is dropped or repeated.
//  Reset clears the sequencer and output valid and loads the settle defaults.
//  Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once and
//  are meant for idle periods. The enable pulse width register is accepted
//  but does not show in any result beat.

module char_lcd_nibble_write_sequencer (
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         cfg_write,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	// request channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  mode,
	input  wire  [7:0]  data_byte,
	input  wire         shift_right,
	input  wire         line_select,
	input  wire  [5:0]  column,
	input  wire  [31:0] number_value,
	// result channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic        kind,
	output logic        reg_select,
	output logic [3:0]  nibble,
	output logic [15:0] pause_after_us,
	output logic        last
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_TRIM = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t              state_q;
	cnlcd_pkg::mode_t    mode_q;
	logic [7:0]          data_q;
	logic                sright_q;
	logic                line_q;
	logic [5:0]          col_q;
	logic [3:0]          idx_q;
	logic [3:0]          ndig_q;

	logic [15:0]         cmd_settle_q;
	logic [15:0]         clr_settle_q;
	logic [15:0]         pwr_wait_q;

	logic                out_valid_q;
	logic                kind_q;
	logic                rs_q;
	logic [3:0]          nib_q;
	logic [15:0]         pause_q;
	logic                last_q;

	cnlcd_pkg::dgt_ctrl_t dgt_ctrl;
	cnlcd_pkg::dgt_stat_t dgt_stat;

	logic                accept;
	logic                load;
	logic                trim_step;

	// beat under construction
	logic                b_kind;
	logic                b_rs;
	logic [7:0]          b_byte;
	logic                b_low;
	logic [15:0]         b_pause_lo;
	logic                b_last;
	logic [3:0]          b_nib;
	logic [15:0]         b_pause;
	logic [3:0]          init_j;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign load      = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign trim_step = (state_q == S_TRIM) && (dgt_stat.top == 4'h0) && (ndig_q > 4'd1);

	assign dgt_ctrl.start = accept && (cnlcd_pkg::mode_t'(mode) == cnlcd_pkg::MODE_NUMBER);
	assign dgt_ctrl.shift = trim_step ||
		(load && (mode_q == cnlcd_pkg::MODE_NUMBER) && idx_q[0]);

	cnlcd_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dgt_ctrl),
		.value  (number_value),
		.stat   (dgt_stat)
	);

	// settle registers; the enable pulse width is not stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_settle_q <= cnlcd_pkg::RST_COMMAND_SETTLE;
			clr_settle_q <= cnlcd_pkg::RST_CLEAR_SETTLE;
			pwr_wait_q   <= cnlcd_pkg::RST_POWERUP_WAIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cnlcd_pkg::CFG_ENABLE_PULSE:   ;
				cnlcd_pkg::CFG_COMMAND_SETTLE: cmd_settle_q <= cfg_data;
				cnlcd_pkg::CFG_CLEAR_SETTLE:   clr_settle_q <= cfg_data;
				cnlcd_pkg::CFG_POWERUP_WAIT:   pwr_wait_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// beat decode from mode and position
	always_comb begin
		init_j     = idx_q - 4'd2;
		b_kind     = 1'b0;
		b_rs       = 1'b0;
		b_byte     = 8'h00;
		b_low      = idx_q[0];
		b_pause_lo = 16'd0;
		b_last     = idx_q[0];
		case (mode_q)
			cnlcd_pkg::MODE_INIT: begin
				b_last = (idx_q == cnlcd_pkg::INIT_LAST_IDX);
				if (idx_q == 4'd0) begin
					b_kind = 1'b1;
					b_low  = 1'b1;
					b_pause_lo = pwr_wait_q;
				end else if (idx_q == 4'd1) begin
					b_byte = {4'h0, cnlcd_pkg::NIB_WAKE};
					b_low  = 1'b1;
				end else begin
					b_byte = cnlcd_pkg::init_cmd(init_j[2:1]);
					b_low  = init_j[0];
					case (init_j[2:1])
						2'd2:    b_pause_lo = clr_settle_q;
						2'd3:    b_pause_lo = 16'd0;
						default: b_pause_lo = cmd_settle_q;
					endcase
				end
			end
			cnlcd_pkg::MODE_CHAR: begin
				b_rs   = 1'b1;
				b_byte = data_q;
			end
			cnlcd_pkg::MODE_COMMAND: b_byte = data_q;
			cnlcd_pkg::MODE_CLEAR: begin
				b_byte     = cnlcd_pkg::CMD_CLEAR;
				b_pause_lo = clr_settle_q;
			end
			cnlcd_pkg::MODE_SHIFT: begin
				b_byte     = sright_q ? cnlcd_pkg::CMD_SHIFT_RIGHT : cnlcd_pkg::CMD_SHIFT_LEFT;
				b_pause_lo = cmd_settle_q;
			end
			cnlcd_pkg::MODE_GOTO: begin
				// column < 64, so the OR touches only bits 5:0 and equals the sum
				b_byte     = (line_q ? cnlcd_pkg::LINE1_BASE : cnlcd_pkg::LINE0_BASE) |
					{2'b00, col_q};
				b_pause_lo = cmd_settle_q;
			end
			cnlcd_pkg::MODE_NUMBER: begin
				b_rs   = 1'b1;
				b_byte = {cnlcd_pkg::ASCII_DIG, dgt_stat.top};
				b_last = idx_q[0] && (ndig_q == 4'd1);
			end
			default: b_last = 1'b1;
		endcase
		b_nib   = b_kind ? 4'h0 : (b_low ? b_byte[3:0] : b_byte[7:4]);
		b_pause = b_low ? b_pause_lo : 16'd0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			ndig_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q  <= '0;
					ndig_q <= cnlcd_pkg::NDIG_MAX;
					if (accept) begin
						if (cnlcd_pkg::mode_t'(mode) == cnlcd_pkg::MODE_NUMBER)
							state_q <= S_CONV;
						else if (mode != cnlcd_pkg::MODE_UNUSED)
							state_q <= S_EMIT;
					end
				end
				S_CONV: begin
					if (!dgt_stat.busy)
						state_q <= S_TRIM;
				end
				S_TRIM: begin
					if (trim_step)
						ndig_q <= ndig_q - 1'b1;
					else
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load) begin
						idx_q <= idx_q + 1'b1;
						if ((mode_q == cnlcd_pkg::MODE_NUMBER) && idx_q[0])
							ndig_q <= ndig_q - 1'b1;
						if (b_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= cnlcd_pkg::mode_t'(mode);
			data_q   <= data_byte;
			sright_q <= shift_right;
			line_q   <= line_select;
			col_q    <= column;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= b_kind;
			rs_q    <= b_rs;
			nib_q   <= b_nib;
			pause_q <= b_pause;
			last_q  <= b_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign reg_select     = rs_q;
	assign nibble         = nib_q;
	assign pause_after_us = pause_q;
	assign last           = last_q;

	a_digits_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && mode_q == cnlcd_pkg::MODE_NUMBER) |->
			(ndig_q != 4'd0 && ndig_q <= cnlcd_pkg::NDIG_MAX))
		else $error("digit count out of range while emitting");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && b_last) |=> (state_q == S_IDLE))
		else $error("sequencer kept running after final beat");

	a_no_beat_converting: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV || state_q == S_TRIM) |-> !load)
		else $error("beat loaded before digits were ready");

	// first emit cycle after the strip: top digit is non-zero unless it is the lone one
	a_top_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && $past(state_q == S_TRIM) && ndig_q > 4'd1) |->
			(dgt_stat.top != 4'h0))
		else $error("leading zero not stripped");

endmodule

`default_nettype wire

[src/cnlcd_digit_unit.sv]
// Shift/add-3 unit: binary to packed BCD, one bit per cycle.
// Depends on cnlcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cnlcd_digit_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire cnlcd_pkg::dgt_ctrl_t      ctrl,
	input  wire [cnlcd_pkg::NUM_W-1:0]     value,
	output cnlcd_pkg::dgt_stat_t           stat
);

	logic [cnlcd_pkg::NUM_W-1:0]  bin_q;
	logic [cnlcd_pkg::BCD_W-1:0]  bcd_q;
	logic [cnlcd_pkg::STEP_W-1:0] step_q;
	logic [cnlcd_pkg::BCD_W-1:0]  bcd_adj;

	// digits of 5 and up get +3 before the shift
	always_comb begin
		for (int d = 0; d < cnlcd_pkg::NDIG; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ?
				bcd_q[4*d +: 4] + 4'd3 : bcd_q[4*d +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctrl.start) begin
			step_q <= cnlcd_pkg::STEP_W'(cnlcd_pkg::NUM_W);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (step_q != '0) begin
			bin_q <= {bin_q[cnlcd_pkg::NUM_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[cnlcd_pkg::BCD_W-2:0], bin_q[cnlcd_pkg::NUM_W-1]};
		end else if (ctrl.shift) begin
			bcd_q <= {bcd_q[cnlcd_pkg::BCD_W-5:0], 4'h0};
		end
	end

	assign stat.busy = (step_q != '0);
	assign stat.top  = bcd_q[cnlcd_pkg::BCD_W-1 -: 4];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !stat.busy)
		else $error("digit unit restarted mid conversion");

	a_no_shift_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |-> !stat.busy)
		else $error("digit shift during conversion");

endmodule

`default_nettype wire
